// ===== hw/rtl/mlfq_pkg.sv =====
package mlfq_pkg;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_PUT = 2'd1,
        CMD_GET = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] proc_id;
        logic [2:0] cur_level;
    } t_in;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_proc;
        logic [2:0] out_level;
        logic       all_empty;
    } t_out;

endpackage

// ===== hw/rtl/multilevel_feedback_queue_scheduler.sv =====
// Channel | Direction | Handshake                         | Payload
// --------+-----------+-----------------------------------+--------------------------
// in      | input     | i_in_valid / o_in_ready           | i_in  (cmd, proc_id, cur_level)
// out     | output    | o_out_valid / i_out_ready         | o_out (status, out_proc,
//         |           |                                   |        out_level, all_empty)
//
// One transfer per cycle in each direction unless the result stalls. A command passes
// the command register, then the result register that also holds the entry RAM read data.
// Level pick is a fixed priority encoder over the per-level occupancy counts.
// Reset (i_rst_n low, synchronous) clears counts, heads and valids; the entry RAM is
// not cleared, since FIFO order only reads slots already written.
// A stalled result holds both stages; the command stage still takes a transfer if empty.
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
#(
    parameter int LEVELS      = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int LW = $clog2(LEVELS);          // level index
    localparam int DW = $clog2(LEVEL_DEPTH);     // slot index
    localparam int CW = $clog2(LEVEL_DEPTH + 1); // occupancy count
    localparam int SW = CW + 1;                  // head + count

    // ---------------- command stage ----------------
    logic r_s1_valid;
    t_in  r_s1;

    // ---------------- queue state ----------------
    logic [CW-1:0] r_cnt  [LEVELS];
    logic [DW-1:0] r_head [LEVELS];
    logic [CW-1:0] n_cnt  [LEVELS];
    logic [DW-1:0] n_head [LEVELS];

    // entry RAM, one row per level
    logic [7:0] r_mem [LEVELS][LEVEL_DEPTH];

    // ---------------- result stage ----------------
    logic          r_out_valid;
    t_status       r_status;
    logic [7:0]    r_proc;
    logic [2:0]    r_level;
    logic          r_empty;
    logic          r_use_rd;   // out_proc comes from the RAM read
    logic          r_push;     // result of an accepted enqueue
    logic [7:0]    r_rd_data;

    logic advance;
    logic fire;

    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_s1_valid && advance;
    assign o_in_ready = !r_s1_valid || advance;

    // ---------------- stage-1 decode ----------------
    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] nonempty_next;
    logic [LW-1:0]     pick;
    logic              any;
    logic [LW-1:0]     tgt;
    logic [3:0]        cur_p1;
    logic              full;
    logic [SW-1:0]     slot_sum;
    logic [DW-1:0]     slot;
    logic [DW-1:0]     head_pick;
    logic              wr_en;
    t_status           s1_status;
    logic [7:0]        s1_proc;
    logic [2:0]        s1_level;
    logic              s1_use_rd;
    logic              s1_push;

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            nonempty[i] = (r_cnt[i] != '0);
        end
    end

    // lowest nonempty level wins
    always_comb begin
        pick = '0;
        any  = |nonempty;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty[i]) begin
                pick = LW'(i);
            end
        end
    end

    // target level: 0 on add, one down (saturating) on put
    assign cur_p1 = {1'b0, r_s1.cur_level} + 4'd1;

    always_comb begin
        tgt = '0;
        if (r_s1.cmd == CMD_PUT) begin
            if (32'(cur_p1) >= LEVELS) begin
                tgt = LW'(LEVELS - 1);
            end else begin
                tgt = LW'(cur_p1);
            end
        end
    end

    assign full     = (r_cnt[tgt] == CW'(LEVEL_DEPTH));
    assign slot_sum = SW'(r_head[tgt]) + SW'(r_cnt[tgt]);
    assign slot     = (slot_sum >= SW'(LEVEL_DEPTH)) ? DW'(slot_sum - SW'(LEVEL_DEPTH))
                                                     : DW'(slot_sum);
    assign head_pick = r_head[pick];

    always_comb begin
        n_cnt     = r_cnt;
        n_head    = r_head;
        wr_en     = 1'b0;
        s1_status = ST_DONE;
        s1_proc   = '0;
        s1_level  = '0;
        s1_use_rd = 1'b0;
        s1_push   = 1'b0;
        unique case (r_s1.cmd)
            CMD_ADD, CMD_PUT: begin
                s1_proc  = r_s1.proc_id;
                s1_level = 3'(tgt);
                if (full) begin
                    s1_status = ST_FULL;
                end else begin
                    wr_en      = 1'b1;
                    s1_push    = 1'b1;
                    n_cnt[tgt] = r_cnt[tgt] + CW'(1);
                end
            end
            CMD_GET: begin
                if (any) begin
                    s1_use_rd    = 1'b1;
                    s1_level     = 3'(pick);
                    n_cnt[pick]  = r_cnt[pick] - CW'(1);
                    n_head[pick] = (head_pick == DW'(LEVEL_DEPTH - 1)) ? '0
                                 : head_pick + DW'(1);
                end else begin
                    s1_status = ST_EMPTY;
                end
            end
            default: begin
                // unused command: no state change, zero result
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            nonempty_next[i] = (n_cnt[i] != '0);
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_cnt[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (fire) begin
                r_cnt  <= n_cnt;
                r_head <= n_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in;
        end
        if (advance) begin
            r_status <= s1_status;
            r_proc   <= s1_proc;
            r_level  <= s1_level;
            r_empty  <= ~|nonempty_next;
            r_use_rd <= s1_use_rd;
            r_push   <= s1_push;
        end
    end

    // entry RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (fire && wr_en) begin
            r_mem[tgt][slot] <= r_s1.proc_id;
        end
        if (advance) begin
            r_rd_data <= r_mem[pick][head_pick];
        end
    end

    // ---------------- outputs ----------------
    assign o_out_valid     = r_out_valid;
    assign o_out.status    = r_status;
    assign o_out.out_proc  = r_use_rd ? r_rd_data : r_proc;
    assign o_out.out_level = r_level;
    assign o_out.all_empty = r_empty;

    // ---------------- assertions ----------------
    a_empty_get_means_all_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_EMPTY) |-> o_out.all_empty)
        else $error("get found nothing but levels not reported empty");

    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_push) |-> (!o_out.all_empty && o_out.status == ST_DONE))
        else $error("accepted enqueue reported all levels empty");

    a_cmd_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1)))
        else $error("command stage lost or changed a stalled command");

endmodule
